// ===== sv/sbmv_pkg.sv =====
// Shared types and codes for the symmetric band matrix-vector multiply block.
package sbmv_pkg;

  // Item opcodes
  localparam logic [1:0] OP_BAND_WR = 2'd0;
  localparam logic [1:0] OP_VEC_WR  = 2'd1;
  localparam logic [1:0] OP_QUERY   = 2'd2;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BAND_WIDTH = 1'd1;

  // Register reset values
  localparam logic [8:0] NUM_ROWS_RST   = 9'd256;
  localparam logic [4:0] BAND_WIDTH_RST = 5'd16;

  // Result status codes
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  // Input beat
  typedef struct packed {
    logic [1:0]         opcode;
    logic [7:0]         row_index;
    logic [3:0]         band_offset;
    logic signed [31:0] value;
  } in_beat_t;

  // Result beat
  typedef struct packed {
    logic [7:0]         result_row;
    logic signed [63:0] product_sum;
    logic               status;
  } out_beat_t;

  // Query sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } state_e;

endpackage

// ===== sv/sym_band_matrix_vector_multiply.sv =====
// Top level: band and vector memories with a sequenced multiply-accumulate for row queries.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------------------
//  in      | input     | in_valid / stall   | in_beat_t: opcode, row, offset, value
//  out     | output    | out_valid / stall  | out_beat_t: row, 64-bit sum, status
//  cfg     | input     | cfg_valid / ready  | register index, write data
//
//  A load beat is written as soon as it is accepted. A query reads each memory once per
//  band term, 2*w+1 terms with w = band width - 1, then drains through a two-stage
//  multiply and accumulate. A row out of range skips the reads and goes straight to done.
//  After reset both memories hold undefined data until written; no clearing pass runs.
//  A result waiting under out_stall_i holds the sequencer in its final state; loads and a
//  new query are still taken while that result waits, once the sequencer is idle.
module sym_band_matrix_vector_multiply
  import sbmv_pkg::*;
#(
  parameter int unsigned MAX_ROWS = 256,
  parameter int unsigned MAX_BAND = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_beat_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_beat_t             out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned ROW_W   = $clog2(MAX_ROWS);
  localparam int unsigned BADDR_W = $clog2(MAX_ROWS * MAX_BAND);
  localparam int unsigned CMP_W   = ($clog2(MAX_ROWS + 1) > 10) ? $clog2(MAX_ROWS + 1) : 10;
  localparam int unsigned K_W     = 6;

  // Configuration registers
  logic [8:0] num_rows_q;
  logic [4:0] band_width_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_rows_q   <= NUM_ROWS_RST;
      band_width_q <= BAND_WIDTH_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_NUM_ROWS:   num_rows_q   <= cfg_data_i[8:0];
        REG_BAND_WIDTH: band_width_q <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  // Effective row count and band half width
  logic [CMP_W-1:0] rows_eff;
  logic [4:0]       bw_eff;
  logic [4:0]       w;

  always_comb begin
    rows_eff = (CMP_W'(num_rows_q) > CMP_W'(MAX_ROWS)) ? CMP_W'(MAX_ROWS) : CMP_W'(num_rows_q);
    if (band_width_q == 5'd0) begin
      bw_eff = 5'd1;
    end else if (9'(band_width_q) > 9'(MAX_BAND)) begin
      bw_eff = 5'(MAX_BAND);
    end else begin
      bw_eff = band_width_q;
    end
    w = bw_eff - 5'd1;
  end

  // Sequencer registers
  state_e             state_q, state_d;
  logic [K_W-1:0]     k_q, k_d;
  logic [7:0]         row_q, row_d;
  logic               status_q, status_d;
  logic signed [63:0] acc_q, acc_d;
  logic               out_valid_q, out_valid_d;
  out_beat_t          out_data_q, out_data_d;

  // Pipeline registers
  logic               s1_v_q, s1_last_q;
  logic               s2_v_q, s2_last_q;
  logic signed [31:0] band_rd_q, vec_rd_q;
  logic signed [63:0] prod_q;

  logic in_accept;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);

  // Term address generation for the current step
  logic [K_W-1:0]     k_last;
  logic               lower;
  logic [4:0]         c;
  logic [CMP_W-1:0]   row_plus_c;
  logic [CMP_W-1:0]   col;
  logic [CMP_W-1:0]   rr;
  logic               term_valid;
  logic [ROW_W-1:0]   mrow;
  logic [ROW_W-1:0]   vec_raddr;
  logic [BADDR_W-1:0] band_raddr;
  logic               rd_en;

  always_comb begin
    k_last     = K_W'(w) << 1;
    lower      = (k_q <= K_W'(w));
    c          = lower ? k_q[4:0] : (k_q[4:0] - w - 5'd1);
    row_plus_c = CMP_W'(row_q) + CMP_W'(c);
    col        = row_plus_c - CMP_W'(w);
    rr         = CMP_W'(row_q) + CMP_W'(w) - CMP_W'(c);
    term_valid = lower ? (row_plus_c >= CMP_W'(w)) : (rr < rows_eff);
    rd_en      = (state_q == ST_RUN);
    if (term_valid) begin
      mrow       = lower ? ROW_W'(row_q) : rr[ROW_W-1:0];
      vec_raddr  = lower ? col[ROW_W-1:0] : rr[ROW_W-1:0];
      band_raddr = BADDR_W'(mrow * MAX_BAND + c);
    end else begin
      mrow       = '0;
      vec_raddr  = '0;
      band_raddr = '0;
    end
  end

  // Write addresses for load beats
  logic               band_we, vec_we;
  logic [ROW_W-1:0]   wrow;
  logic [BADDR_W-1:0] band_waddr;

  always_comb begin
    wrow       = ROW_W'(in_data_i.row_index);
    band_waddr = BADDR_W'(wrow * MAX_BAND + in_data_i.band_offset);
    band_we    = in_accept && (in_data_i.opcode == OP_BAND_WR)
                 && (CMP_W'(in_data_i.row_index) < CMP_W'(MAX_ROWS))
                 && (9'(in_data_i.band_offset) < 9'(MAX_BAND));
    vec_we     = in_accept && (in_data_i.opcode == OP_VEC_WR)
                 && (CMP_W'(in_data_i.row_index) < CMP_W'(MAX_ROWS));
  end

  // Band and vector memories
  logic signed [31:0] band_mem [MAX_ROWS*MAX_BAND];
  logic signed [31:0] vec_mem  [MAX_ROWS];

  always_ff @(posedge clk_i) begin
    if (band_we) begin
      band_mem[band_waddr] <= in_data_i.value;
    end
    if (rd_en) begin
      band_rd_q <= band_mem[band_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (vec_we) begin
      vec_mem[wrow] <= in_data_i.value;
    end
    if (rd_en) begin
      vec_rd_q <= vec_mem[vec_raddr];
    end
  end

  // Multiply stage
  always_ff @(posedge clk_i) begin
    prod_q <= band_rd_q * vec_rd_q;
  end

  // Advance term tags alongside the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q    <= 1'b0;
      s1_last_q <= 1'b0;
      s2_v_q    <= 1'b0;
      s2_last_q <= 1'b0;
    end else begin
      s1_v_q    <= rd_en && term_valid;
      s1_last_q <= rd_en && (k_q == k_last);
      s2_v_q    <= s1_v_q;
      s2_last_q <= s1_last_q;
    end
  end

  // Sequencer next state, accumulator and output register
  always_comb begin
    state_d     = state_q;
    k_d         = k_q;
    row_d       = row_q;
    status_d    = status_q;
    acc_d       = acc_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;

    if (s2_v_q) begin
      acc_d = acc_q + prod_q;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept && (in_data_i.opcode == OP_QUERY)) begin
          row_d = in_data_i.row_index;
          acc_d = '0;
          k_d   = '0;
          if (CMP_W'(in_data_i.row_index) >= rows_eff) begin
            status_d = STATUS_RANGE;
            state_d  = ST_DONE;
          end else begin
            status_d = STATUS_OK;
            state_d  = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        k_d = k_q + K_W'(1);
        if (k_q == k_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (s2_last_q) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d            = 1'b1;
          out_data_d.result_row  = row_q;
          out_data_d.product_sum = acc_q;
          out_data_d.status      = status_q;
          state_d                = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold payload state
  always_ff @(posedge clk_i) begin
    row_q      <= row_d;
    status_q   <= status_d;
    acc_q      <= acc_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTHESIS
  a_range_zero_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.status == STATUS_RANGE)) |-> (out_data_o.product_sum == 64'sd0))
    else $error("out-of-range result carries a nonzero sum");

  a_idle_pipe_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (!s1_v_q && !s2_v_q && !s1_last_q && !s2_last_q))
    else $error("multiply pipeline busy while sequencer idle");

  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (k_q <= k_last))
    else $error("step counter ran past the last band term");

  a_query_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && (in_data_i.opcode == OP_QUERY)) |=> in_stall_o)
    else $error("query beat accepted without stalling the input");
`endif

endmodule
